FILE: rtl/rpbs_pkg.sv
// Shared types and constants for the restart backoff supervisor.
package rpbs_pkg;

  localparam int SLOT_COUNT = 16;
  localparam int SLOT_IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  localparam logic       ACT_ARM     = 1'b0;
  localparam logic       ACT_EXIT    = 1'b1;

  localparam logic [1:0] POL_NEVER   = 2'd0;
  localparam logic [1:0] POL_ALWAYS  = 2'd1;
  localparam logic [1:0] POL_NONZERO = 2'd2;

  localparam logic [2:0] CFG_POLICY  = 3'd0;
  localparam logic [2:0] CFG_MAX     = 3'd1;
  localparam logic [2:0] CFG_WINDOW  = 3'd2;
  localparam logic [2:0] CFG_INIT    = 3'd3;
  localparam logic [2:0] CFG_FACTOR  = 3'd4;
  localparam logic [2:0] CFG_CAP     = 3'd5;

  typedef enum logic [2:0] {
    V_IGNORED    = 3'd0,
    V_STOPPED    = 3'd1,
    V_RESTART    = 3'd2,
    V_ESCALATED  = 3'd3,
    V_SUPPRESSED = 3'd4,
    V_ARMED      = 3'd5
  } verdict_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_BACKOFF,
    S_DONE
  } sup_state_t;

  typedef struct packed {
    logic [31:0] win_base;
    logic [7:0]  restart_cnt;
    logic [7:0]  failure_streak;
    logic        escalated;
  } slot_rec_t;

  typedef struct packed {
    logic                  en;
    logic [SLOT_IDX_W-1:0] idx;
    logic                  active;
    slot_rec_t             rec;
  } tbl_wr_t;

  typedef struct packed {
    logic       start;
    logic [7:0] streak;
  } bo_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] delay_ms;
  } bo_rsp_t;

endpackage

FILE: rtl/rpbs_slot_table.sv
// Per-slot restart records with a valid bit for each slot.
module rpbs_slot_table (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [rpbs_pkg::SLOT_IDX_W-1:0] rd_idx,
  output logic                            rd_active,
  output rpbs_pkg::slot_rec_t             rd_rec,
  input  rpbs_pkg::tbl_wr_t               wr
);
  import rpbs_pkg::*;

  logic      active_r [SLOT_COUNT];
  slot_rec_t rec_r    [SLOT_COUNT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        active_r[i] <= 1'b0;
      end
    end else if (wr.en) begin
      active_r[wr.idx] <= wr.active;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      rec_r[wr.idx] <= wr.rec;
    end
  end

  assign rd_active = active_r[rd_idx];
  assign rd_rec    = rec_r[rd_idx];

endmodule

FILE: rtl/rpbs_backoff.sv
// Iterative backoff delay unit: one Q8.8 multiply and cap compare per cycle.
module rpbs_backoff (
  input  logic              clk,
  input  logic              rst_n,
  input  rpbs_pkg::bo_req_t req,
  input  logic [31:0]       init_ms,
  input  logic [15:0]       factor_q8,
  input  logic [31:0]       cap_ms,
  output rpbs_pkg::bo_rsp_t rsp
);
  import rpbs_pkg::*;

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [7:0]  cnt_r, cnt_nxt;
  logic [7:0]  target_r, target_nxt;
  logic [47:0] d8_r, d8_nxt;
  logic [31:0] delay_r, delay_nxt;
  logic [47:0] cap8;
  logic [55:0] prod;

  assign cap8 = {8'd0, cap_ms, 8'd0};
  // Only multiplied while below the cap, so the low 40 bits hold the whole value.
  assign prod = 56'(d8_r[39:0]) * 56'(factor_q8);

  always_comb begin
    busy_nxt   = busy_r;
    done_nxt   = 1'b0;
    cnt_nxt    = cnt_r;
    target_nxt = target_r;
    d8_nxt     = d8_r;
    delay_nxt  = delay_r;
    if (req.start) begin
      busy_nxt   = 1'b1;
      cnt_nxt    = 8'd0;
      target_nxt = req.streak;
      d8_nxt     = {8'd0, init_ms, 8'd0};
    end else if (busy_r) begin
      if (d8_r >= cap8) begin
        busy_nxt  = 1'b0;
        done_nxt  = 1'b1;
        delay_nxt = cap_ms;
      end else if (cnt_r == target_r) begin
        busy_nxt  = 1'b0;
        done_nxt  = 1'b1;
        delay_nxt = d8_r[39:8];
      end else begin
        d8_nxt  = prod[55:8];
        cnt_nxt = cnt_r + 8'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r    <= cnt_nxt;
    target_r <= target_nxt;
    d8_r     <= d8_nxt;
    delay_r  <= delay_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.delay_ms = delay_r;

endmodule

FILE: rtl/restart_policy_backoff_supervisor.sv
// Restart supervisor top level: config registers, event sequencer and result register.
//
// Each arm or exit transaction is taken one at a time: the block drops in_tready
// after acceptance and raises it again once the result has moved into the output
// register, which can still be waiting on out_tready. Events that grant no restart
// skip the backoff unit. A restart runs the backoff unit, which does one 40x16 Q8.8
// multiply and cap compare per cycle through a single multiplier, multiplying once
// for each failure in the streak (fewer once the cap is reached); the streak stays
// below max_restarts.
// Configuration is taken at any cycle (cfg_ready is tied high) and is meant to be
// written while no event is in flight.
module restart_policy_backoff_supervisor (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // slot[3:0], exit_status[12:4], now_seconds[44:13], zero pad
  input  logic        in_tuser,   // action
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // delay_ms[31:0], restarts_in_window[39:32]
  output logic [2:0]  out_tuser,  // verdict
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import rpbs_pkg::*;

  // configuration registers
  logic [1:0]  policy_r;
  logic [7:0]  max_r;
  logic [15:0] window_r;
  logic [31:0] init_r;
  logic [15:0] factor_r;
  logic [31:0] cap_r;

  sup_state_t state_r, state_nxt;

  logic              action_r;
  logic [3:0]        slot_r;
  logic signed [8:0] code_r;
  logic [31:0]       now_r;

  verdict_t    res_verdict_r, res_verdict_nxt;
  logic [31:0] res_delay_r, res_delay_nxt;
  logic [7:0]  res_count_r, res_count_nxt;

  logic        out_valid_r;
  verdict_t    out_verdict_r;
  logic [31:0] out_delay_r;
  logic [7:0]  out_count_r;

  logic                  accept;
  logic                  load_out;
  logic                  slot_ok;
  logic [SLOT_IDX_W-1:0] idx;
  logic                  rd_active;
  slot_rec_t             rd_rec;
  tbl_wr_t               tbl_wr;
  bo_req_t               bo_req;
  bo_rsp_t               bo_rsp;

  logic        again;
  logic        expired;
  logic [31:0] elapsed;
  slot_rec_t   upd_rec;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r <= POL_NEVER;
      max_r    <= 8'd5;
      window_r <= 16'd60;
      init_r   <= 32'd1000;
      factor_r <= 16'd512;
      cap_r    <= 32'd60000;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_POLICY: policy_r <= cfg_data[1:0];
        CFG_MAX:    max_r    <= cfg_data[7:0];
        CFG_WINDOW: window_r <= cfg_data[15:0];
        CFG_INIT:   init_r   <= cfg_data;
        CFG_FACTOR: factor_r <= cfg_data[15:0];
        CFG_CAP:    cap_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  assign idx     = SLOT_IDX_W'(slot_r);
  assign slot_ok = 32'(slot_r) < SLOT_COUNT;

  rpbs_slot_table u_table (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_idx    (idx),
    .rd_active (rd_active),
    .rd_rec    (rd_rec),
    .wr        (tbl_wr)
  );

  rpbs_backoff u_backoff (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (bo_req),
    .init_ms   (init_r),
    .factor_q8 (factor_r),
    .cap_ms    (cap_r),
    .rsp       (bo_rsp)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) state_nxt = S_EVAL;
      end
      S_EVAL: begin
        if (bo_req.start) state_nxt = S_BACKOFF;
        else              state_nxt = S_DONE;
      end
      S_BACKOFF: begin
        if (bo_rsp.done) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    in_tready = (state_r == S_IDLE);
    load_out  = (state_r == S_DONE) && (!out_valid_r || out_tready);
  end
  assign accept = in_tvalid && in_tready;

  // event evaluation against the slot record
  assign again   = (policy_r == POL_ALWAYS) || ((policy_r == POL_NONZERO) && (code_r != '0));
  assign elapsed = now_r - rd_rec.win_base;
  assign expired = elapsed >= {16'd0, window_r};

  always_comb begin
    upd_rec.win_base       = expired ? now_r : rd_rec.win_base;
    upd_rec.restart_cnt    = expired ? 8'd0 : rd_rec.restart_cnt;
    upd_rec.failure_streak = expired ? 8'd0 : rd_rec.failure_streak;
    upd_rec.escalated      = rd_rec.escalated;
  end

  always_comb begin
    tbl_wr          = '0;
    tbl_wr.idx      = idx;
    tbl_wr.rec      = upd_rec;
    bo_req          = '0;
    res_verdict_nxt = res_verdict_r;
    res_delay_nxt   = res_delay_r;
    res_count_nxt   = res_count_r;
    if (state_r == S_EVAL) begin
      res_verdict_nxt = V_IGNORED;
      res_delay_nxt   = 32'd0;
      res_count_nxt   = 8'd0;
      if (slot_ok) begin
        if (action_r == ACT_ARM) begin
          if (policy_r != POL_NEVER) begin
            res_verdict_nxt = V_ARMED;
            if (!rd_active) begin
              // open a fresh window
              tbl_wr.en  = 1'b1;
              tbl_wr.active = 1'b1;
              tbl_wr.rec = '{win_base: now_r, restart_cnt: 8'd0,
                             failure_streak: 8'd0, escalated: 1'b0};
            end else begin
              res_count_nxt = rd_rec.restart_cnt;
            end
          end else if (rd_active) begin
            res_count_nxt = rd_rec.restart_cnt;
          end
        end else if (rd_active) begin
          tbl_wr.en = 1'b1;
          if (!again) begin
            tbl_wr.active   = 1'b0;
            res_verdict_nxt = V_STOPPED;
          end else begin
            tbl_wr.active = 1'b1;
            res_count_nxt = upd_rec.restart_cnt;
            if (upd_rec.restart_cnt >= max_r) begin
              tbl_wr.rec.escalated = 1'b1;
              res_verdict_nxt = upd_rec.escalated ? V_SUPPRESSED : V_ESCALATED;
            end else begin
              bo_req.start  = 1'b1;
              bo_req.streak = upd_rec.failure_streak;
              if (upd_rec.restart_cnt != 8'hFF) begin
                tbl_wr.rec.restart_cnt = upd_rec.restart_cnt + 8'd1;
                res_count_nxt          = upd_rec.restart_cnt + 8'd1;
              end
              if (upd_rec.failure_streak != 8'hFF) begin
                tbl_wr.rec.failure_streak = upd_rec.failure_streak + 8'd1;
              end
              res_verdict_nxt = V_RESTART;
            end
          end
        end
      end
    end else if ((state_r == S_BACKOFF) && bo_rsp.done) begin
      res_delay_nxt = bo_rsp.delay_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_out)        out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      action_r <= in_tuser;
      slot_r   <= in_tdata[3:0];
      code_r   <= in_tdata[12:4];
      now_r    <= in_tdata[44:13];
    end
    res_verdict_r <= res_verdict_nxt;
    res_delay_r   <= res_delay_nxt;
    res_count_r   <= res_count_nxt;
    if (load_out) begin
      out_verdict_r <= res_verdict_r;
      out_delay_r   <= res_delay_r;
      out_count_r   <= res_count_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_verdict_r;
  assign out_tdata  = {out_count_r, out_delay_r};

endmodule

FILE: tb/rpbs_event_checker.sv
// Scoreboard for the restart supervisor: keeps its own slot records and checks every verdict.
module rpbs_event_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [47:0] in_tdata,   // slot[3:0], exit_status[12:4], now_seconds[44:13], zero pad
  input  logic        in_tuser,   // action
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [39:0] out_tdata,  // delay_ms[31:0], restarts_in_window[39:32]
  input  logic [2:0]  out_tuser,  // verdict
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          failures,
  output int          outstanding
);
  import rpbs_pkg::*;

  typedef struct packed {
    verdict_t    verdict;
    logic [31:0] delay_ms;
    logic [7:0]  restarts;
  } sup_result_t;

  logic [1:0]  policy_reg;
  logic [7:0]  max_reg;
  logic [15:0] window_reg;
  logic [31:0] init_reg;
  logic [15:0] factor_reg;
  logic [31:0] cap_reg;

  logic        slot_on     [SLOT_COUNT];
  logic [31:0] win_start   [SLOT_COUNT];
  logic [7:0]  restart_cnt [SLOT_COUNT];
  logic [7:0]  streak_cnt  [SLOT_COUNT];
  logic        escalated   [SLOT_COUNT];

  sup_result_t expected_results[$];

  // Delay carried with 8 fraction bits; stop at the cap as soon as it is reached.
  function automatic logic [31:0] predict_delay(input logic [7:0] streak);
    logic [63:0] cap_q8;
    logic [63:0] dly_q8;
    int          i;
    cap_q8 = {24'd0, cap_reg, 8'd0};
    dly_q8 = {24'd0, init_reg, 8'd0};
    if (dly_q8 >= cap_q8) return cap_reg;
    for (i = 0; i < streak; i++) begin
      dly_q8 = (dly_q8 * {48'd0, factor_reg}) >> 8;
      if (dly_q8 >= cap_q8) return cap_reg;
    end
    return dly_q8[39:8];
  endfunction

  function automatic sup_result_t supervise_event(input logic act, input logic [3:0] s,
                                                  input logic [8:0] code, input logic [31:0] t);
    sup_result_t r;
    logic        retry;
    r.verdict  = V_IGNORED;
    r.delay_ms = '0;
    r.restarts = '0;
    if (act == ACT_ARM) begin
      if (policy_reg != POL_NEVER) begin
        // a re-arm keeps the existing record
        if (!slot_on[s]) begin
          slot_on[s]     = 1'b1;
          win_start[s]   = t;
          restart_cnt[s] = '0;
          streak_cnt[s]  = '0;
          escalated[s]   = 1'b0;
        end
        r.verdict = V_ARMED;
      end
      if (slot_on[s]) r.restarts = restart_cnt[s];
    end else if (slot_on[s]) begin
      // the unnamed policy code behaves like never on exit
      retry = (policy_reg == POL_ALWAYS) || (policy_reg == POL_NONZERO && code != '0);
      if (!retry) begin
        slot_on[s] = 1'b0;
        r.verdict  = V_STOPPED;
      end else begin
        // expired window clears the counts but keeps the escalation mark
        if (t - win_start[s] >= {16'd0, window_reg}) begin
          win_start[s]   = t;
          restart_cnt[s] = '0;
          streak_cnt[s]  = '0;
        end
        if (restart_cnt[s] >= max_reg) begin
          if (!escalated[s]) begin
            escalated[s] = 1'b1;
            r.verdict    = V_ESCALATED;
          end else begin
            r.verdict = V_SUPPRESSED;
          end
        end else begin
          r.delay_ms = predict_delay(streak_cnt[s]);
          if (restart_cnt[s] != 8'hFF) restart_cnt[s] = restart_cnt[s] + 8'd1;
          if (streak_cnt[s] != 8'hFF) streak_cnt[s] = streak_cnt[s] + 8'd1;
          r.verdict = V_RESTART;
        end
        r.restarts = restart_cnt[s];
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin : sample
    sup_result_t want;
    int          k;
    if (!rst_n) begin
      policy_reg = POL_NEVER;
      max_reg    = 8'd5;
      window_reg = 16'd60;
      init_reg   = 32'd1000;
      factor_reg = 16'd512;
      cap_reg    = 32'd60000;
      for (k = 0; k < SLOT_COUNT; k++) slot_on[k] = 1'b0;
      expected_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_POLICY: policy_reg = cfg_data[1:0];
          CFG_MAX:    max_reg    = cfg_data[7:0];
          CFG_WINDOW: window_reg = cfg_data[15:0];
          CFG_INIT:   init_reg   = cfg_data;
          CFG_FACTOR: factor_reg = cfg_data[15:0];
          CFG_CAP:    cap_reg    = cfg_data;
          default: ;
        endcase
      end
      // results first: one taken this edge belongs to an earlier transaction
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          $error("result with nothing expected: verdict %0d delay_ms %0d restarts_in_window %0d",
                 out_tuser, out_tdata[31:0], out_tdata[39:32]);
          failures++;
        end else begin
          want = expected_results.pop_front();
          if (out_tuser !== want.verdict) begin
            $error("verdict: expected %0d, actual %0d", want.verdict, out_tuser);
            failures++;
          end
          if (out_tdata[31:0] !== want.delay_ms) begin
            $error("delay_ms: expected %0d, actual %0d", want.delay_ms, out_tdata[31:0]);
            failures++;
          end
          if (out_tdata[39:32] !== want.restarts) begin
            $error("restarts_in_window: expected %0d, actual %0d", want.restarts,
                   out_tdata[39:32]);
            failures++;
          end
        end
      end
      if (in_tvalid && in_tready)
        expected_results.insert(expected_results.size(),
                                supervise_event(in_tuser, in_tdata[3:0], in_tdata[12:4],
                                                in_tdata[44:13]));
    end
    outstanding = expected_results.size();
  end

endmodule

FILE: tb/tb_restart_policy_backoff_supervisor.sv
// Testbench top for the restart supervisor: clock, reset, stimulus, flow control and verdict.
module tb_restart_policy_backoff_supervisor;
  import rpbs_pkg::*;

  localparam logic [1:0]        POL_RESERVED  = 2'd3;
  localparam logic signed [8:0] CODE_ABNORMAL = -9'sd1;
  localparam int IDLE_LIMIT = 5000;
  localparam int LONG_HOLD  = 400;
  localparam int SETTLE_GAP = 8;
  localparam int DRAIN_TAIL = 300;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata   = '0;   // slot[3:0], exit_status[12:4], now_seconds[44:13], zero pad
  logic        in_tuser   = 1'b0; // action
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;         // delay_ms[31:0], restarts_in_window[39:32]
  logic [2:0]  out_tuser;         // verdict
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index  = '0;
  logic [31:0] cfg_data   = '0;

  int failures;
  int outstanding;

  logic        no_idle        = 1'b0;
  logic        long_hold_req  = 1'b0;
  logic        long_hold_done = 1'b0;
  int          rx_hold;
  int          rx_calm;
  int          tx_calm;
  int          quiet_cycles;
  logic [31:0] wall_now   = 32'd0;
  int          cur_window = 60;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  restart_policy_backoff_supervisor dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  rpbs_event_checker scoreboard (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .failures    (failures),
    .outstanding (outstanding)
  );

  // Receiver: random stall bursts, calm runs, and one long hold-off on request.
  always @(negedge clk) begin
    if (rx_hold > 0) begin
      rx_hold--;
      out_tready <= 1'b0;
    end else if (long_hold_req && !long_hold_done) begin
      long_hold_done = 1'b1;
      rx_hold = LONG_HOLD - 1;
      out_tready <= 1'b0;
    end else if (no_idle || rx_calm > 0) begin
      if (rx_calm > 0) rx_calm--;
      out_tready <= 1'b1;
    end else begin
      case ($urandom_range(0, 15))
        0: begin
          rx_hold = $urandom_range(0, 16);
          out_tready <= 1'b0;
        end
        1: begin
          rx_calm = $urandom_range(20, 200);
          out_tready <= 1'b1;
        end
        default: out_tready <= 1'b1;
      endcase
    end
  end

  // End the run when no transaction moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("tb_restart_policy_backoff_supervisor NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Enter and leave at a falling edge; valid stays high so back-to-back items need no dip.
  task automatic send_event(input logic act, input logic [3:0] s,
                            input logic signed [8:0] code, input logic [31:0] t);
    int gap;
    gap = 0;
    if (!no_idle) begin
      if (tx_calm > 0) begin
        tx_calm--;
      end else begin
        case ($urandom_range(0, 7))
          0: gap = $urandom_range(1, 17);
          1: tx_calm = $urandom_range(5, 40);
          default: ;
        endcase
      end
    end
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {3'b000, t, code, s};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // Hold the sender until every expected result has come back.
  task automatic settle_block();
    in_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE_GAP) @(negedge clk);
  endtask

  task automatic program_regs(input logic [1:0] pol, input logic [7:0] maxr,
                              input logic [15:0] win, input logic [31:0] init_ms,
                              input logic [15:0] fac, input logic [31:0] cap);
    logic [31:0] vals [6];
    logic [2:0]  idxs [6];
    int          k;
    settle_block();
    vals = '{{30'd0, pol}, {24'd0, maxr}, {16'd0, win}, init_ms, {16'd0, fac}, cap};
    idxs = '{CFG_POLICY, CFG_MAX, CFG_WINDOW, CFG_INIT, CFG_FACTOR, CFG_CAP};
    cur_window = int'(win);
    for (k = 0; k < 6; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idxs[k];
      cfg_data  <= vals[k];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic program_random();
    logic [1:0]  pol;
    logic [7:0]  maxr;
    logic [15:0] win;
    logic [31:0] init_ms;
    logic [15:0] fac;
    logic [31:0] cap;
    if ($urandom_range(0, 5) == 0) pol = 2'($urandom_range(0, 3));
    else pol = $urandom_range(0, 1) ? POL_ALWAYS : POL_NONZERO;
    maxr = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 8));
    win = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535))
                                      : 16'($urandom_range(0, 80));
    init_ms = $urandom() >> $urandom_range(0, 31);
    fac = $urandom_range(0, 1) ? 16'($urandom_range(0, 65535)) : 16'($urandom_range(200, 800));
    cap = $urandom() >> $urandom_range(0, 31);
    program_regs(pol, maxr, win, init_ms, fac, cap);
  endtask

  // Mostly small time steps so windows fill up; jump_pct sets how often time leaps.
  task automatic run_traffic(input int count, input int slot_hi, input int arm_pct,
                             input int jump_pct);
    int                n;
    int                r;
    logic              act;
    logic [3:0]        s;
    logic signed [8:0] code;
    for (n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if (r < jump_pct) wall_now = wall_now + $urandom_range(0, 2 * cur_window + 2);
      else if (r < 2 * jump_pct) wall_now = $urandom();
      else wall_now = wall_now + $urandom_range(0, 2);
      act = ($urandom_range(0, 99) < arm_pct) ? ACT_ARM : ACT_EXIT;
      s = 4'($urandom_range(0, slot_hi));
      case ($urandom_range(0, 9))
        0, 1:    code = CODE_ABNORMAL;
        2, 3:    code = '0;
        default: code = 9'($urandom_range(1, 255));
      endcase
      send_event(act, s, code, wall_now);
    end
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // registers at reset: policy never, so nothing arms
    send_event(ACT_ARM, 4'd0, 9'sd0, 32'd0);
    send_event(ACT_EXIT, 4'd0, CODE_ABNORMAL, 32'd0);

    program_regs(POL_ALWAYS, 8'd2, 16'd10, 32'd100, 16'h0180, 32'd1000);
    send_event(ACT_ARM, 4'd0, 9'sd0, 32'd0);
    send_event(ACT_ARM, 4'd0, 9'sd0, 32'd5);
    send_event(ACT_EXIT, 4'd0, 9'sd0, 32'd1);
    send_event(ACT_EXIT, 4'd0, CODE_ABNORMAL, 32'd2);
    send_event(ACT_EXIT, 4'd0, 9'sd255, 32'd3);
    send_event(ACT_EXIT, 4'd0, 9'sd1, 32'd4);
    send_event(ACT_EXIT, 4'd0, CODE_ABNORMAL, 32'd20);
    send_event(ACT_EXIT, 4'd0, 9'sd7, 32'd21);
    send_event(ACT_EXIT, 4'd0, 9'sd7, 32'd22);
    send_event(ACT_EXIT, 4'd15, 9'sd7, 32'd22);
    send_event(ACT_ARM, 4'd15, 9'sd0, 32'hFFFF_FFFF);
    send_event(ACT_EXIT, 4'd15, CODE_ABNORMAL, 32'd5);

    program_regs(POL_NONZERO, 8'd2, 16'd10, 32'd100, 16'h0180, 32'd1000);
    send_event(ACT_EXIT, 4'd15, 9'sd0, 32'd6);
    send_event(ACT_EXIT, 4'd0, 9'sd255, 32'd40);
    send_event(ACT_EXIT, 4'd0, 9'sd0, 32'd41);

    program_regs(POL_RESERVED, 8'd2, 16'd10, 32'd100, 16'h0180, 32'd1000);
    send_event(ACT_ARM, 4'd3, 9'sd0, 32'd50);
    send_event(ACT_ARM, 4'd4, 9'sd0, 32'd50);
    send_event(ACT_EXIT, 4'd3, CODE_ABNORMAL, 32'd51);

    program_regs(POL_NEVER, 8'd2, 16'd10, 32'd100, 16'h0180, 32'd1000);
    send_event(ACT_ARM, 4'd4, 9'sd0, 32'd52);
    send_event(ACT_ARM, 4'd5, 9'sd0, 32'd52);
    send_event(ACT_EXIT, 4'd4, CODE_ABNORMAL, 32'd53);

    program_regs(POL_ALWAYS, 8'd5, 16'd60, 32'd1000, 16'd512, 32'd60000);
    long_hold_req <= 1'b1;
    run_traffic(100, 15, 25, 6);
    settle_block();
    run_traffic(100, 15, 25, 6);

    // zero limits and zero window: retried exits open a new window and never restart
    program_regs(POL_NONZERO, 8'd0, 16'd0, 32'd0, 16'd0, 32'd0);
    run_traffic(120, 7, 30, 6);

    program_regs(POL_ALWAYS, 8'd255, 16'hFFFF, 32'd1, 16'hFFFF, 32'hFFFF_FFFF);
    run_traffic(150, 1, 5, 1);

    // one slot, slow growth: long backoff loops up to the count limit
    program_regs(POL_ALWAYS, 8'd255, 16'hFFFF, 32'd1000, 16'h0101, 32'hFFFF_FFFF);
    run_traffic(300, 0, 3, 0);

    program_regs(POL_RESERVED, 8'd3, 16'd30, 32'd250, 16'h0300, 32'd20000);
    run_traffic(100, 15, 40, 6);

    repeat (3) begin
      program_random();
      run_traffic(130, 15, 25, 6);
    end

    program_random();
    no_idle <= 1'b1;
    run_traffic(130, 15, 25, 6);

    in_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_TAIL) @(negedge clk);
    if (failures == 0) begin
      $display("tb_restart_policy_backoff_supervisor OK");
    end else begin
      $display("tb_restart_policy_backoff_supervisor NOT OK");
    end
    $finish;
  end

endmodule
